### rtl/otgp_pkg.sv
`default_nettype none
package otgp_pkg;

    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned ANGLE_BITS_DEF   = 16;
    localparam int unsigned TAB_LEN          = 24;
    localparam logic signed [39:0] POS_MAX   = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] POS_MIN   = 40'sh80_0000_0000;
    localparam logic signed [63:0] GAIN_Q30  = 64'sd652032875;
    localparam logic signed [17:0] COS_RESET = 18'sd65536;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] odom_x;
        logic signed [31:0] odom_y;
        logic signed [39:0] fix_x;
        logic signed [39:0] fix_y;
        logic        [15:0] fix_heading;
        logic        [47:0] time_ms;
    } req_t;

    typedef struct packed {
        logic signed [39:0] out_x;
        logic signed [39:0] out_y;
        logic        [15:0] out_angle;
        logic        [47:0] out_time_ms;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_LOAD   = 4'd0,
        OP_YAW0   = 4'd1,
        OP_VEC    = 4'd2,
        OP_ROT0   = 4'd3,
        OP_ROT    = 4'd4,
        OP_SC     = 4'd5,
        OP_MUL0   = 4'd6,
        OP_MUL1   = 4'd7,
        OP_MUL2   = 4'd8,
        OP_SUM    = 4'd9,
        OP_OUT    = 4'd10,
        OP_NONE   = 4'd11
    } op_t;

    typedef struct packed {
        op_t          op;
        logic [4:0]   step;
    } cmd_t;

    typedef struct packed {
        logic kind;
    } sts_t;

    function automatic logic [31:0] atan_raw(input logic [4:0] i);
        case (i)
            5'd0: atan_raw = 32'd536870912;  5'd1: atan_raw = 32'd316933406;
            5'd2: atan_raw = 32'd167458907;  5'd3: atan_raw = 32'd85004756;
            5'd4: atan_raw = 32'd42667331;   5'd5: atan_raw = 32'd21354465;
            5'd6: atan_raw = 32'd10679838;   5'd7: atan_raw = 32'd5340245;
            5'd8: atan_raw = 32'd2670163;    5'd9: atan_raw = 32'd1335087;
            5'd10: atan_raw = 32'd667544;    5'd11: atan_raw = 32'd333772;
            5'd12: atan_raw = 32'd166886;    5'd13: atan_raw = 32'd83443;
            5'd14: atan_raw = 32'd41722;     5'd15: atan_raw = 32'd20861;
            5'd16: atan_raw = 32'd10430;     5'd17: atan_raw = 32'd5215;
            5'd18: atan_raw = 32'd2608;      5'd19: atan_raw = 32'd1304;
            5'd20: atan_raw = 32'd652;       5'd21: atan_raw = 32'd326;
            5'd22: atan_raw = 32'd163;       5'd23: atan_raw = 32'd81;
            default: atan_raw = 32'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

### rtl/otgp_ctrl.sv
`default_nettype none
module otgp_ctrl
    import otgp_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire  logic out_stall,
    input  wire  sts_t sts,
    output cmd_t       cmd
);
    localparam int unsigned NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
    localparam logic [4:0] LAST = 5'(NSTEP - 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_YAW0 = 11'b000_0000_0010,
        S_VEC  = 11'b000_0000_0100,
        S_ROT0 = 11'b000_0000_1000,
        S_ROT  = 11'b000_0001_0000,
        S_SC   = 11'b000_0010_0000,
        S_MUL0 = 11'b000_0100_0000,
        S_MUL1 = 11'b000_1000_0000,
        S_MUL2 = 11'b001_0000_0000,
        S_SUM  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       full_reg, full_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = full_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        full_next  = full_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        if (full_reg && !out_stall)
        begin
            full_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_YAW0;
                end
            end
            S_YAW0:
            begin
                cmd.op     = OP_YAW0;
                step_next  = 5'd0;
                state_next = S_VEC;
            end
            S_VEC:
            begin
                cmd.op    = OP_VEC;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST)
                begin
                    state_next = sts.kind ? S_MUL0 : S_ROT0;
                end
            end
            S_ROT0:
            begin
                cmd.op     = OP_ROT0;
                step_next  = 5'd0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.op    = OP_ROT;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST)
                begin
                    state_next = S_SC;
                end
            end
            S_SC:
            begin
                cmd.op     = OP_SC;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                cmd.op     = OP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!full_reg || !out_stall)
                begin
                    cmd.op     = OP_OUT;
                    full_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 5'd0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            full_reg  <= full_next;
        end
    end
endmodule
`default_nettype wire

### rtl/otgp_dp.sv
`default_nettype none
module otgp_dp
    import otgp_pkg::*;
#(
    parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  req_t req,
    input  wire  cmd_t cmd,
    output sts_t       sts,
    output rsp_t       rsp
);
    localparam int unsigned AB = ANGLE_BITS;

    req_t                  req_reg;
    logic signed [63:0]    cx_reg, cy_reg;
    logic        [AB-1:0]  z_reg;
    logic signed [AB+1:0]  zr_reg;
    logic                  zero_reg;
    logic                  neg_reg;
    logic signed [39:0]    bx_reg, by_reg;
    logic        [15:0]    bth_reg;
    logic signed [17:0]    bs_reg, bc_reg;
    logic signed [49:0]    p0_reg, p1_reg;
    logic signed [49:0]    rx_reg, ry_reg;
    rsp_t                  rsp_reg;

    logic signed [31:0]    m0, m1, m2, m3;
    logic signed [63:0]    sterm, cterm, xs, ys;
    logic        [31:0]    tab_r;
    logic        [AB-1:0]  tab;
    logic        [AB+15:0] yaw_w;
    logic        [15:0]    yaw16, theta;
    logic                  neg;
    logic signed [15:0]    rs;
    logic signed [AB+17:0] zw;
    logic signed [AB+1:0]  z0;
    logic signed [63:0]    cxn, cyn, cr, sr;
    logic signed [17:0]    cc, ss;
    logic signed [49:0]    rxr, ryr;
    logic signed [40:0]    sx, sy;

    function automatic logic signed [17:0] clamp18(input logic signed [63:0] v);
        if (v > 64'sd131071)       clamp18 = 18'sd131071;
        else if (v < -64'sd131072) clamp18 = -18'sd131072;
        else                       clamp18 = v[17:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
        if (v > 41'(POS_MAX))      sat40 = POS_MAX;
        else if (v < 41'(POS_MIN)) sat40 = POS_MIN;
        else                       sat40 = v[39:0];
    endfunction

    assign sts.kind = req_reg.kind;
    assign rsp      = rsp_reg;

    always_comb
    begin
        m0    = req_reg.quat_w * req_reg.quat_z;
        m1    = req_reg.quat_x * req_reg.quat_y;
        m2    = req_reg.quat_y * req_reg.quat_y;
        m3    = req_reg.quat_z * req_reg.quat_z;
        sterm = 64'sd2 * (64'(m0) + 64'(m1));
        cterm = 64'sd1073741824 - 64'sd2 * (64'(m2) + 64'(m3));
        tab_r = atan_raw(cmd.step);
        tab   = AB'((33'(tab_r) + (33'd1 << (31 - AB))) >> (32 - AB));
        xs    = cx_reg >>> cmd.step;
        ys    = cy_reg >>> cmd.step;
        // scale the turn to 16 bits, rounding half up when narrowing
        yaw_w = {z_reg, 16'd0} + ((AB+16)'(1) << (AB - 1));
        yaw16 = zero_reg ? 16'd0 : yaw_w[AB+15:AB];
        theta = req_reg.fix_heading - yaw16;
        // fold theta into the right half plane, flip the result back later
        neg   = theta[15] ^ theta[14];
        rs    = neg ? signed'(theta ^ 16'h8000) : signed'(theta);
        zw    = ((AB+18)'(rs) <<< AB) >>> 16;
        z0    = zw[AB+1:0];
        cxn   = neg_reg ? -cx_reg : cx_reg;
        cyn   = neg_reg ? -cy_reg : cy_reg;
        cr    = (cxn + 64'sd8192) >>> 14;
        sr    = (cyn + 64'sd8192) >>> 14;
        cc    = clamp18(cr);
        ss    = clamp18(sr);
        rxr   = (p0_reg - p1_reg + 50'sd32768) >>> 16;
        ryr   = (rx_reg + ry_reg + 50'sd32768) >>> 16;
        sx    = req_reg.kind ? 41'(rx_reg) + 41'(bx_reg) : 41'(req_reg.fix_x) - 41'(rx_reg);
        sy    = req_reg.kind ? 41'(ry_reg) + 41'(by_reg) : 41'(req_reg.fix_y) - 41'(ry_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg  <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            z_reg    <= '0;
            zr_reg   <= '0;
            zero_reg <= 1'b0;
            neg_reg  <= 1'b0;
            bx_reg   <= '0;
            by_reg   <= '0;
            bth_reg  <= '0;
            bs_reg   <= '0;
            bc_reg   <= COS_RESET;
            p0_reg   <= '0;
            p1_reg   <= '0;
            rx_reg   <= '0;
            ry_reg   <= '0;
            rsp_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD: req_reg <= req;
                OP_YAW0:
                begin
                    zero_reg <= (cterm == 0 && sterm == 0);
                    if (cterm < 0)
                    begin
                        cx_reg <= -cterm; cy_reg <= -sterm;
                        z_reg  <= AB'(1) << (AB - 1);
                    end
                    else
                    begin
                        cx_reg <= cterm; cy_reg <= sterm; z_reg <= '0;
                    end
                end
                OP_VEC:
                begin
                    if (cy_reg >= 0)
                    begin
                        cx_reg <= cx_reg + ys; cy_reg <= cy_reg - xs; z_reg <= z_reg + tab;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys; cy_reg <= cy_reg + xs; z_reg <= z_reg - tab;
                    end
                end
                OP_ROT0:
                begin
                    cx_reg  <= GAIN_Q30;
                    cy_reg  <= '0;
                    zr_reg  <= z0;
                    neg_reg <= neg;
                    bth_reg <= theta;
                end
                OP_ROT:
                begin
                    if (zr_reg >= 0)
                    begin
                        cx_reg <= cx_reg - ys; cy_reg <= cy_reg + xs;
                        zr_reg <= zr_reg - (AB+2)'(tab);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ys; cy_reg <= cy_reg - xs;
                        zr_reg <= zr_reg + (AB+2)'(tab);
                    end
                end
                OP_SC:
                begin
                    bc_reg <= cc;
                    bs_reg <= ss;
                end
                OP_MUL0:
                begin
                    p0_reg <= 50'(req_reg.odom_x) * 50'(bc_reg);
                    p1_reg <= 50'(req_reg.odom_y) * 50'(bs_reg);
                end
                OP_MUL1:
                begin
                    rx_reg <= 50'(req_reg.odom_x) * 50'(bs_reg);
                    ry_reg <= 50'(req_reg.odom_y) * 50'(bc_reg);
                    p0_reg <= rxr;
                end
                OP_MUL2:
                begin
                    ry_reg <= ryr;
                    rx_reg <= p0_reg;
                end
                OP_SUM:
                begin
                    if (!req_reg.kind)
                    begin
                        bx_reg <= sat40(sx);
                        by_reg <= sat40(sy);
                    end
                end
                OP_OUT:
                begin
                    rsp_reg.out_x       <= req_reg.kind ? sat40(sx) : bx_reg;
                    rsp_reg.out_y       <= req_reg.kind ? sat40(sy) : by_reg;
                    rsp_reg.out_angle   <= req_reg.kind ? yaw16 + bth_reg : bth_reg;
                    rsp_reg.out_time_ms <= req_reg.time_ms;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/odometry_to_global_pose.sv
`default_nettype none
// Channel   Direction  Handshake           Payload
// request   in         in_valid/in_stall   req_t  (kind, quaternion, odometry, fix, time)
// response  out        out_valid/out_stall rsp_t  (x, y, angle, time)
//
// One request at a time: the next request is taken only once the response to
// the last has been loaded into the output register (steps capped at 24).
// Every request runs the iterative CORDIC yaw vectoring pass; an anchor then
// adds a sine/cosine rotation pass.
// Reset leaves base at zero with cosine one; no clearing pass.
// A finished response waits in the output register while the next
// request is taken; a stalled response holds, and the next one waits behind it.
module odometry_to_global_pose
    import otgp_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int unsigned ANGLE_BITS   = ANGLE_BITS_DEF
)
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic in_valid,
    output logic       in_stall,
    input  wire  req_t in_data,
    output logic       out_valid,
    input  wire  logic out_stall,
    output rsp_t       pose
);
    cmd_t cmd;
    sts_t sts;

    otgp_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    otgp_dp #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts), .rsp(pose)
    );
endmodule
`default_nettype wire

### tb/sv/otgp_checker.sv
module otgp_checker
    import otgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  req_t        in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  rsp_t        pose,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NSTEP = 16;
    localparam int unsigned ABITS = 16;

    rsp_t pose_q[$];
    logic signed [39:0] anchor_x;
    logic signed [39:0] anchor_y;
    logic [15:0] anchor_theta;
    logic signed [17:0] anchor_sin;
    logic signed [17:0] anchor_cos;

    function automatic longint atan_step(int i);
        longint raw;
        raw = longint'(atan_raw(5'(i)));
        return (raw + (64'sd1 <<< (31 - ABITS))) >>> (32 - ABITS);
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [39:0] clip40(longint v);
        if (v > longint'(POS_MAX)) return POS_MAX;
        if (v < longint'(POS_MIN)) return POS_MIN;
        return v[39:0];
    endfunction

    function automatic logic signed [17:0] clip18(longint v);
        if (v > 131071) return 18'sd131071;
        if (v < -131072) return -18'sd131072;
        return v[17:0];
    endfunction

    function automatic logic [15:0] heading_of(longint y, longint x);
        logic [31:0] z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'd1 << (ABITS - 1);
        end
        for (int i = 0; i < NSTEP; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + 32'(atan_step(i));
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - 32'(atan_step(i));
            end
        end
        return z[15:0];
    endfunction

    task automatic load_rotation(input logic [15:0] theta);
        longint r;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit flip;
        r = theta;
        flip = 0;
        x = GAIN_Q30;
        y = 0;
        if (r >= 16384 && r < 49152)
        begin
            r -= 32768;
            flip = 1;
        end
        else if (r >= 49152)
            r -= 65536;
        z = r;
        for (int i = 0; i < NSTEP; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z -= atan_step(i);
            end
            else
            begin
                x = x + ys; y = y - xs; z += atan_step(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        anchor_cos = clip18(rnd_shift(x, 14));
        anchor_sin = clip18(rnd_shift(y, 14));
    endtask

    task automatic predict_pose(input req_t r);
        longint st;
        longint ct;
        longint ox;
        longint oy;
        longint rx;
        longint ry;
        logic [15:0] yaw;
        rsp_t p;
        st = 2 * (longint'(r.quat_w) * r.quat_z + longint'(r.quat_x) * r.quat_y);
        ct = (64'sd1 <<< 30) - 2 * (longint'(r.quat_y) * r.quat_y
                                   + longint'(r.quat_z) * r.quat_z);
        yaw = heading_of(st, ct);
        ox = r.odom_x;
        oy = r.odom_y;
        if (r.kind == 1'b0)
        begin
            anchor_theta = r.fix_heading - yaw;
            load_rotation(anchor_theta);
        end
        rx = rnd_shift(ox * anchor_cos - oy * anchor_sin, 16);
        ry = rnd_shift(ox * anchor_sin + oy * anchor_cos, 16);
        if (r.kind == 1'b0)
        begin
            anchor_x = clip40(longint'(r.fix_x) - rx);
            anchor_y = clip40(longint'(r.fix_y) - ry);
            p.out_x = anchor_x;
            p.out_y = anchor_y;
            p.out_angle = anchor_theta;
        end
        else
        begin
            p.out_x = clip40(rx + anchor_x);
            p.out_y = clip40(ry + anchor_y);
            p.out_angle = yaw + anchor_theta;
        end
        p.out_time_ms = r.time_ms;
        pose_q.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            anchor_x = '0;
            anchor_y = '0;
            anchor_theta = '0;
            anchor_sin = '0;
            anchor_cos = COS_RESET;
            fail_count = 0;
            pose_q.delete();
            pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_pose(in_data);
            if (out_valid && !out_stall)
            begin
                if (pose_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected pose %h", pose);
                end
                else
                begin
                    e = pose_q.pop_front();
                    if (e !== pose)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display({"pose mismatch: exp x=%0d y=%0d a=%0d t=%0d",
                                      " got x=%0d y=%0d a=%0d t=%0d"},
                                     e.out_x, e.out_y, e.out_angle, e.out_time_ms,
                                     pose.out_x, pose.out_y, pose.out_angle,
                                     pose.out_time_ms);
                    end
                end
            end
            pending = pose_q.size();
        end
    end
endmodule

### tb/sv/tb.sv
module tb;
    import otgp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t pose;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;
    bit calm = 0;        // long stretch with no idling on either side

    localparam int unsigned CYCLE_LIMIT = 1000000;

    odometry_to_global_pose dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .pose(pose)
    );

    otgp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .pose(pose),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog: bound the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stall: about 22 in 100, none during the calm stretch.
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 22);

    // Random request field with extremes weighted in.
    function automatic logic [63:0] pick(int w);
        logic [63:0] v;
        case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1 << (w - 1);
            3: v = (64'd1 << (w - 1)) - 1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Unit-ish quaternion for a yaw of choice (binary angle), with small tilt.
    function automatic req_t make_pose(logic k, logic [15:0] yaw16);
        req_t r;
        real a;
        a = 3.14159265358979 * yaw16 / 65536.0;
        r.kind = k;
        r.quat_w = 16'($rtoi(32767.0 * $cos(a)));
        r.quat_z = 16'($rtoi(32767.0 * $sin(a)));
        r.quat_x = 16'($signed($urandom_range(400)) - 200);
        r.quat_y = 16'($signed($urandom_range(400)) - 200);
        r.odom_x = $signed($urandom_range(2000000)) - 1000000;
        r.odom_y = $signed($urandom_range(2000000)) - 1000000;
        r.fix_x = 40'({$urandom, $urandom} >> 28);
        r.fix_y = 40'({$urandom, $urandom} >> 28);
        r.fix_heading = 16'($urandom);
        r.time_ms = 48'({$urandom, $urandom});
        return r;
    endfunction

    function automatic req_t make_noise();
        req_t r;
        r.kind = 1'($urandom);
        r.quat_w = 16'(pick(16));
        r.quat_x = 16'(pick(16));
        r.quat_y = 16'(pick(16));
        r.quat_z = 16'(pick(16));
        r.odom_x = 32'(pick(32));
        r.odom_y = 32'(pick(32));
        r.fix_x = 40'(pick(40));
        r.fix_y = 40'(pick(40));
        r.fix_heading = 16'(pick(16));
        r.time_ms = 48'(pick(48));
        return r;
    endfunction

    // Present one request, hold it through stalls, then advance.
    // Stall is checked at the falling edge, before the edge that takes the request.
    task automatic send(input req_t r);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        req_t r;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: transform before any anchor uses the reset base.
        r = make_noise();
        r.kind = 1'b1;
        send(r);
        // All-zero quaternion: the yaw vector is (1.0, 0), giving zero yaw.
        r = '0;
        r.fix_heading = 16'hFFFF;
        r.time_ms = '1;
        send(r);
        r.kind = 1'b1;
        send(r);
        // Position overflow toward both rails.
        r = make_pose(1'b0, 16'h4000);
        r.fix_x = POS_MAX; r.fix_y = POS_MIN;
        r.odom_x = 32'sh8000_0000; r.odom_y = 32'sh7FFF_FFFF;
        send(r);
        r.kind = 1'b1;
        send(r);
        r.odom_x = 32'sh7FFF_FFFF; r.odom_y = 32'sh8000_0000;
        send(r);
        // Non-unit quaternions at the extremes, and headings around the turn.
        for (int i = 0; i < 16; i++)
        begin
            if (i < 8)
                r = make_noise();
            else
                r = make_pose(i[0], 16'(i * 8192));
            send(r);
        end

        // Random: mostly anchor/transform runs with sane poses, some noise.
        for (int n = 0; n < 1600; n++)
        begin
            calm = (n >= 600 && n < 800);
            if ($urandom_range(9) < 2)
                r = make_noise();
            else
                r = make_pose(($urandom_range(5) != 0), 16'($urandom));
            send(r);
        end
        in_valid <= 1'b0;
        calm = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### files.f
rtl/otgp_pkg.sv
rtl/otgp_ctrl.sv
rtl/otgp_dp.sv
rtl/odometry_to_global_pose.sv
tb/sv/otgp_checker.sv
tb/sv/tb.sv
